### sv/lzss_window_pixel_decoder_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the LZSS window pixel decoder
// Shared property forms, so that every check reads the same way.
// ----------------------------------------------------------------------------
`ifndef LZSS_WINDOW_PIXEL_DECODER_MACROS_SVH
`define LZSS_WINDOW_PIXEL_DECODER_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define LWPD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lwpd check failed");

// Next-cycle implication, switched off while reset is high.
`define LWPD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lwpd check failed");

`endif

### sv/lwpd_pkg.sv
// ----------------------------------------------------------------------------
// LZSS window pixel decoder package
// Shared types, constants and helper functions of the decoder.
// ----------------------------------------------------------------------------
package lwpd_pkg;

  localparam int WINDOW_SIZE = 4096;
  localparam int DIM_W       = 13;
  localparam int POS_W       = 12;
  localparam int LEN_W       = 5;
  localparam logic [DIM_W-1:0] MAX_DIM  = 13'd4096;
  localparam logic [DIM_W-1:0] MIN_DIM  = 13'd1;
  localparam logic [DIM_W-1:0] RST_WIDTH  = 13'd256;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 13'd224;
  localparam logic [LEN_W-1:0] LEN_BIAS = 5'd3;
  localparam logic [7:0] FLAG_EMPTY  = 8'h01;
  localparam logic [7:0] FLAG_MARKER = 8'h80;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_FLAG     = 2'd0,
    PH_LITERAL  = 2'd1,
    PH_MATCH_HI = 2'd2,
    PH_MATCH_LO = 2'd3
  } phase_t;

  typedef enum logic [0:0] {
    ST_TOKEN = 1'b0,
    ST_COPY  = 1'b1
  } dec_state_t;

  typedef struct packed {
    logic [7:0] compressed_byte;
    logic       start_image;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       pixel;
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic             run_last;
    logic             image_last;
  } out_item_t;

  typedef struct packed {
    logic step;
    logic clear;
  } pos_ctrl_t;

  typedef struct packed {
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic             at_end;
    logic             done;
  } pos_stat_t;

  // Out-of-range dimensions saturate: zero acts as one, anything larger
  // than the maximum acts as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < MIN_DIM) begin
      r = MIN_DIM;
    end else if (v > MAX_DIM) begin
      r = MAX_DIM;
    end
    return r;
  endfunction

endpackage

### sv/lwpd_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with a registered read; a read of the
// address being written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module lwpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lwpd_pkg::WINDOW_SIZE
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/lwpd_pos.sv
// ----------------------------------------------------------------------------
// LZSS window pixel decoder raster position tracker
// Keeps column and row of the next pixel and flags the end of the image.
// ----------------------------------------------------------------------------
module lwpd_pos (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lwpd_pkg::DIM_W-1:0]  width,
  input  logic [lwpd_pkg::DIM_W-1:0]  height,
  input  lwpd_pkg::pos_ctrl_t         ctrl,
  output lwpd_pkg::pos_stat_t         stat
);

  logic [lwpd_pkg::POS_W-1:0] column;
  logic [lwpd_pkg::POS_W-1:0] row;
  logic                       done;

  logic [lwpd_pkg::POS_W-1:0] col_base;
  logic [lwpd_pkg::POS_W-1:0] row_base;
  logic                       done_base;
  logic [lwpd_pkg::DIM_W-1:0] col_p1;
  logic [lwpd_pkg::DIM_W-1:0] row_p1;
  logic                       col_end;
  logic                       img_end;
  logic [lwpd_pkg::POS_W-1:0] column_next;
  logic [lwpd_pkg::POS_W-1:0] row_next;
  logic                       done_next;

  // A new image clears the position before the pixel of the same request.
  always_comb begin
    col_base  = ctrl.clear ? '0 : column;
    row_base  = ctrl.clear ? '0 : row;
    done_base = ctrl.clear ? 1'b0 : done;
    col_p1    = {1'b0, col_base} + 13'd1;
    row_p1    = {1'b0, row_base} + 13'd1;
    col_end   = (col_p1 >= width);
    img_end   = col_end && (row_p1 >= height);

    column_next = col_base;
    row_next    = row_base;
    done_next   = done_base;
    if (ctrl.step) begin
      if (col_end) begin
        column_next = '0;
        if (img_end) begin
          done_next = 1'b1;
        end else begin
          row_next = row_p1[lwpd_pkg::POS_W-1:0];
        end
      end else begin
        column_next = col_p1[lwpd_pkg::POS_W-1:0];
      end
    end

    stat.column = col_base;
    stat.row    = row_base;
    stat.at_end = img_end;
    stat.done   = done_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
      done   <= 1'b0;
    end else begin
      column <= column_next;
      row    <= row_next;
      done   <= done_next;
    end
  end

endmodule

### sv/lzss_window_pixel_decoder.sv
// ----------------------------------------------------------------------------
// LZSS window pixel decoder
// Decodes an LZSS byte stream with a 4096-byte history ring into pixels in
// raster order. Flag and match high bytes only update the decoder state, a
// literal emits one pixel, and a match low byte starts the history read;
// the copy then emits up to 18 pixels and takes no byte until it ends. The
// copy rate is set by the single read port of the history RAM, whose
// registered read is overlapped with the write of the previous pixel
// through a forwarding register. Output stalls hold the copy in place. The
// history RAM is not cleared; a match must only reach pixels already decoded.
// ----------------------------------------------------------------------------
`include "lzss_window_pixel_decoder_macros.svh"

module lzss_window_pixel_decoder #(
  parameter int WINDOW_SIZE = lwpd_pkg::WINDOW_SIZE
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        src_valid,
  output logic                        src_ready,
  input  lwpd_pkg::in_item_t          src_item,
  output logic                        pix_valid,
  input  logic                        pix_ready,
  output lwpd_pkg::out_item_t         pix_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  lwpd_pkg::cfg_reg_t          cfg_index,
  input  logic [lwpd_pkg::DIM_W-1:0]  cfg_data
);

  localparam int AW = $clog2(WINDOW_SIZE);

  lwpd_pkg::dec_state_t state, state_next;
  lwpd_pkg::phase_t     phase, phase_next;
  logic [7:0]           flag_shift, flag_shift_next;
  logic [7:0]           match_hi, match_hi_next;
  logic [AW-1:0]        wp, wp_next;
  logic [AW-1:0]        src_ptr, src_ptr_next;
  logic [lwpd_pkg::LEN_W-1:0] remain, remain_next;
  logic                 fwd_hit;
  logic [7:0]           fwd_data;
  logic [lwpd_pkg::DIM_W-1:0] width_reg, height_reg;

  logic                 advance;
  logic                 in_fire;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [7:0]           ram_rdata;
  logic                 emit;
  logic [7:0]           emit_pixel;
  logic                 emit_run_last;
  logic [7:0]           copy_pixel;
  logic [7:0]           in_byte;
  lwpd_pkg::phase_t     phase_eff;
  logic [7:0]           flag_eff;
  logic [AW-1:0]        wp_eff;
  logic [AW-1:0]        match_src;
  lwpd_pkg::pos_ctrl_t  pos_ctrl;
  lwpd_pkg::pos_stat_t  pos_stat;

  // Phase that follows once the current token is used up.
  function automatic lwpd_pkg::phase_t flag_phase(input logic [7:0] fs);
    lwpd_pkg::phase_t p;
    if (fs[7:1] == 7'd0) begin
      p = lwpd_pkg::PH_FLAG;
    end else if (fs[0]) begin
      p = lwpd_pkg::PH_MATCH_HI;
    end else begin
      p = lwpd_pkg::PH_LITERAL;
    end
    return p;
  endfunction

  assign cfg_ready = 1'b1;
  assign advance   = !pix_valid || pix_ready;
  assign src_ready = (state == lwpd_pkg::ST_TOKEN) && advance;
  assign in_fire   = src_valid && src_ready;
  assign in_byte   = src_item.compressed_byte;
  assign copy_pixel = fwd_hit ? fwd_data : ram_rdata;

  always_comb begin
    phase_eff = src_item.start_image ? lwpd_pkg::PH_FLAG : phase;
    flag_eff  = src_item.start_image ? lwpd_pkg::FLAG_EMPTY : flag_shift;
    // A request still waiting during a copy must not move the write address.
    wp_eff    = (in_fire && src_item.start_image) ? '0 : wp;
    match_src = wp_eff - AW'({match_hi[3:0], in_byte}) - AW'(1);

    state_next      = state;
    phase_next      = phase;
    flag_shift_next = flag_shift;
    match_hi_next   = match_hi;
    wp_next         = wp;
    src_ptr_next    = src_ptr;
    remain_next     = remain;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_raddr       = src_ptr;
    emit            = 1'b0;
    emit_pixel      = copy_pixel;
    emit_run_last   = 1'b0;
    pos_ctrl.clear  = in_fire && src_item.start_image;

    unique case (state)
      lwpd_pkg::ST_TOKEN: begin
        if (in_fire) begin
          phase_next      = phase_eff;
          flag_shift_next = flag_eff;
          wp_next         = wp_eff;
          if (src_item.start_image) begin
            match_hi_next = '0;
          end
          if (!pos_stat.done) begin
            unique case (phase_eff)
              lwpd_pkg::PH_FLAG: begin
                flag_shift_next = lwpd_pkg::FLAG_MARKER | {1'b0, in_byte[7:1]};
                phase_next = in_byte[0] ? lwpd_pkg::PH_MATCH_HI : lwpd_pkg::PH_LITERAL;
              end
              lwpd_pkg::PH_LITERAL: begin
                emit            = 1'b1;
                emit_pixel      = in_byte;
                emit_run_last   = 1'b1;
                ram_we          = 1'b1;
                wp_next         = wp_eff + AW'(1);
                flag_shift_next = flag_eff >> 1;
                phase_next      = flag_phase(flag_eff);
              end
              lwpd_pkg::PH_MATCH_HI: begin
                match_hi_next = in_byte;
                phase_next    = lwpd_pkg::PH_MATCH_LO;
              end
              lwpd_pkg::PH_MATCH_LO: begin
                // Fetch the first source pixel now; it arrives next cycle.
                ram_re       = 1'b1;
                ram_raddr    = match_src;
                src_ptr_next = match_src + AW'(1);
                remain_next  = {1'b0, match_hi[7:4]} + lwpd_pkg::LEN_BIAS;
                state_next   = lwpd_pkg::ST_COPY;
              end
              default: begin
                phase_next = lwpd_pkg::PH_FLAG;
              end
            endcase
          end
        end
      end
      lwpd_pkg::ST_COPY: begin
        if (advance) begin
          emit    = 1'b1;
          ram_we  = 1'b1;
          wp_next = wp + AW'(1);
          if ((remain == lwpd_pkg::LEN_W'(1)) || pos_stat.at_end) begin
            emit_run_last   = 1'b1;
            state_next      = lwpd_pkg::ST_TOKEN;
            flag_shift_next = flag_shift >> 1;
            phase_next      = flag_phase(flag_shift);
          end else begin
            ram_re       = 1'b1;
            ram_raddr    = src_ptr;
            src_ptr_next = src_ptr + AW'(1);
            remain_next  = remain - lwpd_pkg::LEN_W'(1);
          end
        end
      end
      default: begin
        state_next = lwpd_pkg::ST_TOKEN;
      end
    endcase

    pos_ctrl.step = emit;
  end

  lwpd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_SIZE)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_eff),
    .wdata (emit_pixel),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lwpd_pos u_pos (
    .clk    (clk),
    .rst    (rst),
    .width  (lwpd_pkg::clamp_dim(width_reg)),
    .height (lwpd_pkg::clamp_dim(height_reg)),
    .ctrl   (pos_ctrl),
    .stat   (pos_stat)
  );

  // A read of the entry being written this cycle sees the new pixel here,
  // which is what makes a distance of one repeat the last pixel.
  always_ff @(posedge clk) begin
    if (ram_re) begin
      fwd_hit  <= ram_we && (ram_raddr == wp_eff);
      fwd_data <= emit_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lwpd_pkg::ST_TOKEN;
      phase      <= lwpd_pkg::PH_FLAG;
      flag_shift <= lwpd_pkg::FLAG_EMPTY;
      match_hi   <= '0;
      wp         <= '0;
      pix_valid  <= 1'b0;
      width_reg  <= lwpd_pkg::RST_WIDTH;
      height_reg <= lwpd_pkg::RST_HEIGHT;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      flag_shift <= flag_shift_next;
      match_hi   <= match_hi_next;
      wp         <= wp_next;
      if (emit) begin
        pix_valid <= 1'b1;
      end else if (pix_ready) begin
        pix_valid <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          lwpd_pkg::REG_WIDTH:  width_reg  <= cfg_data;
          lwpd_pkg::REG_HEIGHT: height_reg <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    src_ptr <= src_ptr_next;
    remain  <= remain_next;
    if (emit) begin
      pix_item.pixel      <= emit_pixel;
      pix_item.column     <= pos_stat.column;
      pix_item.row        <= pos_stat.row;
      pix_item.run_last   <= emit_run_last;
      pix_item.image_last <= pos_stat.at_end;
    end
  end

  `LWPD_ASSERT_SAME(a_last_ends_run, clk, rst,
    pix_valid && pix_item.image_last, pix_item.run_last)
  `LWPD_ASSERT_SAME(a_copy_holds_on_stall, clk, rst,
    (state == lwpd_pkg::ST_COPY) && pix_valid && !pix_ready, !ram_re && !ram_we)
  `LWPD_ASSERT_NEXT(a_low_byte_starts_copy, clk, rst,
    in_fire && !pos_stat.done && (phase_eff == lwpd_pkg::PH_MATCH_LO),
    state == lwpd_pkg::ST_COPY)

endmodule

### tb/lzss_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS pixel stream checker
// Watches the byte, pixel and register channels of the LZSS window pixel
// decoder. It keeps its own copy of the decoder state and history ring,
// expands each accepted byte into the pixels it should produce, and compares
// every accepted pixel field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module lzss_pixel_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        src_valid,
  input  logic                        src_ready,
  input  lwpd_pkg::in_item_t          src_item,
  input  logic                        pix_valid,
  input  logic                        pix_ready,
  input  lwpd_pkg::out_item_t         pix_item,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  lwpd_pkg::cfg_reg_t          cfg_index,
  input  logic [lwpd_pkg::DIM_W-1:0]  cfg_data,
  output int                          mismatches,
  output int                          pixels_due
);
  import lwpd_pkg::*;

  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [7:0]       flag_bits;
  phase_t           phase;
  logic [7:0]       hi_byte;
  logic [7:0]       ring [WINDOW_SIZE];
  logic [11:0]      wr_ptr;
  int               col;
  int               row;
  bit               done_flag;
  out_item_t        expected_pixels [$];
  int               errs = 0;

  function automatic int dim_limit(input logic [DIM_W-1:0] v);
    if (v == 0) begin
      return 1;
    end
    if (v > MAX_DIM) begin
      return MAX_DIM;
    end
    return v;
  endfunction

  task automatic restart_image();
    flag_bits = FLAG_EMPTY;
    phase     = PH_FLAG;
    hi_byte   = 8'h00;
    wr_ptr    = '0;
    col       = 0;
    row       = 0;
    done_flag = 1'b0;
  endtask

  task automatic put_pixel(input logic [7:0] v, input bit final_of_byte);
    out_item_t px;
    ring[wr_ptr] = v;
    wr_ptr       = wr_ptr + 1'b1;
    px.pixel      = v;
    px.column     = 12'(col);
    px.row        = 12'(row);
    px.image_last = 1'b0;
    if (col + 1 >= dim_limit(width_reg)) begin
      col = 0;
      if (row + 1 >= dim_limit(height_reg)) begin
        done_flag     = 1'b1;
        px.image_last = 1'b1;
      end else begin
        row++;
      end
    end else begin
      col++;
    end
    // A match cut short by the end of the image ends its run there.
    px.run_last = final_of_byte || done_flag;
    expected_pixels.push_back(px);
  endtask

  task automatic advance_flag();
    logic bit_now;
    bit_now   = flag_bits[0];
    flag_bits = flag_bits >> 1;
    if (flag_bits == 8'h00) begin
      phase = PH_FLAG;
    end else begin
      phase = bit_now ? PH_MATCH_HI : PH_LITERAL;
    end
  endtask

  task automatic decode_byte(input in_item_t it);
    logic [7:0]  b;
    logic [11:0] rd_ptr;
    logic [12:0] distance;
    int          len;
    b = it.compressed_byte;
    if (it.start_image) begin
      restart_image();
    end
    if (done_flag) begin
      return;
    end
    case (phase)
      PH_FLAG: begin
        flag_bits = FLAG_MARKER | (b >> 1);
        phase     = b[0] ? PH_MATCH_HI : PH_LITERAL;
      end
      PH_LITERAL: begin
        put_pixel(b, 1'b1);
        advance_flag();
      end
      PH_MATCH_HI: begin
        hi_byte = b;
        phase   = PH_MATCH_LO;
      end
      default: begin
        len      = int'(hi_byte[7:4]) + int'(LEN_BIAS);
        distance = {1'b0, hi_byte[3:0], b} + 13'd1;
        rd_ptr   = wr_ptr - distance[11:0];
        // Byte by byte, so an overlapping copy repeats what it has just written.
        for (int i = 0; i < len && !done_flag; i++) begin
          put_pixel(ring[rd_ptr], i == len - 1);
          rd_ptr = rd_ptr + 1'b1;
        end
        advance_flag();
      end
    endcase
  endtask

  task automatic check_pixel(input out_item_t got);
    out_item_t want;
    if (expected_pixels.size() == 0) begin
      $error("unexpected pixel %0d at column %0d, row %0d", got.pixel, got.column, got.row);
      errs++;
      return;
    end
    want = expected_pixels.pop_front();
    if (got.pixel !== want.pixel) begin
      $error("pixel: expected %0d, actual %0d", want.pixel, got.pixel);
      errs++;
    end
    if (got.column !== want.column) begin
      $error("column: expected %0d, actual %0d", want.column, got.column);
      errs++;
    end
    if (got.row !== want.row) begin
      $error("row: expected %0d, actual %0d", want.row, got.row);
      errs++;
    end
    if (got.run_last !== want.run_last) begin
      $error("run_last: expected %0d, actual %0d", want.run_last, got.run_last);
      errs++;
    end
    if (got.image_last !== want.image_last) begin
      $error("image_last: expected %0d, actual %0d", want.image_last, got.image_last);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = RST_WIDTH;
      height_reg = RST_HEIGHT;
      restart_image();
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WIDTH) begin
          width_reg = cfg_data;
        end else begin
          height_reg = cfg_data;
        end
      end
      // Predict before comparing, in case a pixel leaves in its byte's cycle.
      if (src_valid && src_ready) begin
        decode_byte(src_item);
      end
      if (pix_valid && pix_ready) begin
        check_pixel(pix_item);
      end
    end
    pixels_due <= expected_pixels.size();
    mismatches <= errs;
  end

endmodule

### tb/lzss_window_pixel_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS window pixel decoder testbench
// Builds compressed streams of flag groups, literals and matches that only
// reach history already written, runs them through several image sizes with
// random stalls on both sides, and leaves all checking to the pixel checker.
// ----------------------------------------------------------------------------
module lzss_window_pixel_decoder_tb;
  import lwpd_pkg::*;

  localparam int TAIL_CYCLES = 24;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 src_valid = 1'b0;
  logic                 src_ready;
  in_item_t             src_item  = '0;
  logic                 pix_valid;
  logic                 pix_ready = 1'b0;
  out_item_t            pix_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  cfg_reg_t             cfg_index = REG_WIDTH;
  logic [DIM_W-1:0]     cfg_data  = '0;
  int                   mismatches;
  int                   pixels_due;
  int                   quiet_cycles = 0;

  // Shadow of the stream being generated: which ring entries hold data,
  // where the next pixel goes and how many the current image still takes.
  bit                   ring_filled [WINDOW_SIZE];
  logic [11:0]          gen_wp = '0;
  int                   gen_left = 0;
  int                   img_px = 1;
  bit                   need_start = 1'b1;
  logic [7:0]           grp_flags;
  logic [7:0]           grp_bytes [$];
  int                   grp_n;
  bit                   grp_start;
  int                   sent;
  bit                   gaps_allowed = 1'b1;
  bit                   src_gaps = 1'b1;
  bit                   pix_gaps = 1'b1;
  int                   hold_asked = 0;
  int                   hold_done = 0;

  lzss_window_pixel_decoder DUT (.*);
  lzss_pixel_checker u_checker (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (src_valid && src_ready) || (pix_valid && pix_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Pixel sink: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_done != hold_asked) begin
        hold_done = hold_asked;
        pix_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (pix_gaps && $urandom_range(0, 5) == 0) begin
        pix_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      pix_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic s);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_item  <= in_item_t'{compressed_byte: b, start_image: s};
    do @(posedge clk); while (!src_ready);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [DIM_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic drain();
    src_valid <= 1'b0;
    @(posedge clk);
    while (pixels_due != 0) @(posedge clk);
    // A trailing flag or match high byte may still be in flight.
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic start_phase(input int raw_w, input int raw_h);
    int ew;
    int eh;
    drain();
    write_reg(REG_WIDTH, DIM_W'(raw_w));
    write_reg(REG_HEIGHT, DIM_W'(raw_h));
    cfg_valid <= 1'b0;
    ew = (raw_w == 0) ? 1 : (raw_w > MAX_DIM) ? MAX_DIM : raw_w;
    eh = (raw_h == 0) ? 1 : (raw_h > MAX_DIM) ? MAX_DIM : raw_h;
    img_px     = ew * eh;
    need_start = 1'b1;
    sent       = 0;
  endtask

  function automatic bit copy_ok(input int distance, input int len);
    int n;
    n = (len < gen_left) ? len : gen_left;
    // Beyond the distance the copy reads pixels that it writes itself.
    if (distance < n) begin
      n = distance;
    end
    for (int i = 0; i < n; i++) begin
      if (!ring_filled[(int'(gen_wp) - distance + i) & (WINDOW_SIZE - 1)]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic fill_ring(input int n);
    int k;
    k = (n < gen_left) ? n : gen_left;
    repeat (k) begin
      ring_filled[gen_wp] = 1'b1;
      gen_wp = gen_wp + 1'b1;
    end
    gen_left -= k;
  endtask

  task automatic open_group(input bit s);
    grp_start = s;
    grp_n     = 0;
    grp_flags = 8'($urandom);
    grp_bytes.delete();
    if (s) begin
      gen_wp   = '0;
      gen_left = img_px;
    end
  endtask

  task automatic add_literal(input logic [7:0] v);
    grp_flags[grp_n] = 1'b0;
    grp_bytes.push_back(v);
    grp_n++;
    fill_ring(1);
  endtask

  task automatic add_match(input int len, input int distance);
    logic [3:0]  len_code;
    logic [11:0] dist_code;
    len_code  = 4'(len - int'(LEN_BIAS));
    dist_code = 12'(distance - 1);
    grp_flags[grp_n] = 1'b1;
    grp_bytes.push_back({len_code, dist_code[11:8]});
    grp_bytes.push_back(dist_code[7:0]);
    grp_n++;
    fill_ring(len);
  endtask

  // A short group leaves the decoder mid-group, so the next one must restart.
  task automatic close_group();
    send_byte(grp_flags, grp_start);
    foreach (grp_bytes[i]) begin
      send_byte(grp_bytes[i], 1'b0);
    end
    sent += grp_bytes.size() + 1;
    need_start = (grp_n < 8) || (gen_left == 0);
  endtask

  task automatic trailing_noise(input int n);
    repeat (n) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic random_group(input int long_pct);
    int keep;
    int len;
    int distance;
    bit s;
    s    = need_start || ($urandom_range(0, 19) == 0);
    keep = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : 8;
    src_gaps = gaps_allowed && ($urandom_range(0, 3) != 0);
    pix_gaps = gaps_allowed && ($urandom_range(0, 3) != 0);
    open_group(s);
    for (int k = 0; k < keep && gen_left > 0; k++) begin
      if ($urandom_range(0, 99) < 55) begin
        len = ($urandom_range(0, 99) < long_pct) ? $urandom_range(15, 18)
                                                 : $urandom_range(3, 18);
        case ($urandom_range(0, 3))
          0:       distance = $urandom_range(1, 4);
          1:       distance = $urandom_range(1, 64);
          2:       distance = $urandom_range(1, 1024);
          default: distance = $urandom_range(1, WINDOW_SIZE);
        endcase
        if (!copy_ok(distance, len)) begin
          distance = $urandom_range(1, 4);
        end
        if (copy_ok(distance, len)) begin
          add_match(len, distance);
        end else begin
          add_literal(8'($urandom_range(0, 255)));
        end
      end else begin
        add_literal(8'($urandom_range(0, 255)));
      end
    end
    close_group();
    if (gen_left == 0) begin
      trailing_noise($urandom_range(0, 2));
    end
  endtask

  task automatic random_phase(input int raw_w, input int raw_h, input int budget,
                              input int long_pct, input bit long_hold);
    start_phase(raw_w, raw_h);
    if (long_hold) begin
      hold_asked++;
    end
    while (sent < budget) begin
      random_group(long_pct);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: a 5 x 2 image with repeats, a match cut short at the end of
    // the image, bytes ignored after it, and a new image copying from the
    // far end of the ring, which still holds the previous image.
    start_phase(5, 2);
    open_group(1'b1);
    add_literal(8'h00);
    add_literal(8'hFF);
    add_match(3, 1);
    add_literal(8'hA5);
    add_match(18, 1);
    close_group();
    trailing_noise(2);
    open_group(1'b1);
    add_match(3, WINDOW_SIZE);
    add_literal(8'h5A);
    add_match(18, 4);
    close_group();
    open_group(1'b1);
    for (int i = 0; i < 8; i++) begin
      add_literal(8'(8'h11 * i));
    end
    close_group();
    open_group(1'b0);
    add_literal(8'h80);
    add_literal(8'h7F);
    close_group();

    random_phase(1, 3, 25, 20, 1'b0);
    random_phase(0, 0, 15, 20, 1'b0);
    random_phase(7, 5, 50, 30, 1'b1);
    random_phase(8191, 1, 30, 80, 1'b0);
    random_phase(1, 4096, 25, 80, 1'b0);
    random_phase(4096, 4096, 20, 50, 1'b0);

    // Last stretch runs at full rate on both sides.
    gaps_allowed = 1'b0;
    pix_gaps     = 1'b0;
    random_phase(6, 4, 25, 30, 1'b0);

    drain();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
